// File: design/vertex_gradient_tint_defines.svh
// ----------------------------------------------------------------------------
// Vertex gradient tint assertion macros
// Concurrent assertion forms used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef VERTEX_GRADIENT_TINT_DEFINES_SVH
`define VERTEX_GRADIENT_TINT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VGT_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VGT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: design/vgt_pkg.sv
// ----------------------------------------------------------------------------
// Vertex gradient tint package
// Item types, command codes, register indexes and queue sizing.
// ----------------------------------------------------------------------------
package vgt_pkg;

	localparam int TABLE_ENTRIES_DEFAULT = 256;
	localparam int GRAD_W                = 24;
	localparam int QUEUE_DEPTH           = 4;
	localparam int QAW                   = $clog2(QUEUE_DEPTH);
	localparam int QCW                   = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_INDEX_W           = 2;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ADVANCE = 2'd1,
		CMD_SHADE   = 2'd2
	} cmd_e;

	localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_MODE      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRADIENT_ENABLE = 2'd1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [7:0]         table_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [7:0]         color_r;
		logic [7:0]         color_g;
		logic [7:0]         color_b;
		logic [7:0]         phase_step;
		logic               batch_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] shaded_r;
		logic [7:0] shaded_g;
		logic [7:0] shaded_b;
		logic       last_of_batch;
	} out_item_t;

	typedef struct packed {
		logic [7:0]        base_r;
		logic [7:0]        base_g;
		logic [7:0]        base_b;
		logic [GRAD_W-1:0] grad;
		logic              batch_end;
	} q_entry_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           empty;
	} q_status_t;

endpackage

// File: design/vgt_ram.sv
// ----------------------------------------------------------------------------
// Vertex gradient tint RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module vgt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/vgt_front.sv
// ----------------------------------------------------------------------------
// Vertex gradient tint front end
// Accepts items, applies loads and phase steps, and looks up the gradient.
// ----------------------------------------------------------------------------
module vgt_front #(
	parameter int TABLE_ENTRIES = vgt_pkg::TABLE_ENTRIES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vgt_pkg::in_item_t  in_item,
	input  logic               gradient_enable,
	input  vgt_pkg::q_status_t q_status,
	output logic               push_valid,
	output vgt_pkg::q_entry_t  push_entry
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int RW = 14;
	localparam logic [RW-1:0] MODULUS = RW'(TABLE_ENTRIES);
	localparam logic [vgt_pkg::QCW:0] OCC_LIMIT = (vgt_pkg::QCW + 1)'(vgt_pkg::QUEUE_DEPTH);

	logic                      in_fire;
	logic [7:0]                phase_q;
	logic [7:0]                phase_d;
	logic [7:0]                sum8;
	logic [RW-1:0]             rem;
	logic [AW-1:0]             raddr;
	logic                      we;
	logic                      re;
	logic [vgt_pkg::QCW:0]     occ;
	logic                      valid_s1;
	logic [7:0]                base_r_s1;
	logic [7:0]                base_g_s1;
	logic [7:0]                base_b_s1;
	logic                      batch_s1;
	logic [vgt_pkg::GRAD_W-1:0] rdata;

	assign occ      = {1'b0, q_status.count} + {{vgt_pkg::QCW{1'b0}}, valid_s1};
	assign in_ready = (occ < OCC_LIMIT);
	assign in_fire  = in_valid && in_ready;

	assign sum8 = in_item.pos_x[7:0] + in_item.pos_y[7:0] + in_item.pos_z[7:0] + phase_q;

	always_comb begin
		rem = RW'(sum8);
		for (int k = 3; k >= 0; k--) begin
			if (rem >= (MODULUS << k)) begin
				rem = rem - (MODULUS << k);
			end
		end
	end

	assign raddr = rem[AW-1:0];

	always_comb begin
		we      = 1'b0;
		re      = 1'b0;
		phase_d = phase_q;
		if (in_fire) begin
			case (in_item.cmd)
				vgt_pkg::CMD_LOAD: begin
					we = (11'(in_item.table_index) < 11'(TABLE_ENTRIES));
				end
				vgt_pkg::CMD_ADVANCE: begin
					if (gradient_enable) begin
						phase_d = phase_q + in_item.phase_step;
					end
				end
				vgt_pkg::CMD_SHADE: begin
					re = gradient_enable;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 8'd0;
			valid_s1 <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			valid_s1 <= re;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			base_r_s1 <= in_item.color_r;
			base_g_s1 <= in_item.color_g;
			base_b_s1 <= in_item.color_b;
			batch_s1  <= in_item.batch_end;
		end
	end

	vgt_ram #(
		.WIDTH(vgt_pkg::GRAD_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(in_item.table_index)),
		.wdata({in_item.color_r, in_item.color_g, in_item.color_b}),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign push_valid           = valid_s1;
	assign push_entry.base_r    = base_r_s1;
	assign push_entry.base_g    = base_g_s1;
	assign push_entry.base_b    = base_b_s1;
	assign push_entry.grad      = rdata;
	assign push_entry.batch_end = batch_s1;

endmodule

// File: design/vgt_queue.sv
// ----------------------------------------------------------------------------
// Vertex gradient tint queue
// Short FIFO of looked-up vertices between the front and back ends.
// ----------------------------------------------------------------------------
module vgt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  vgt_pkg::q_entry_t  push_entry,
	input  logic               pop,
	output vgt_pkg::q_entry_t  head,
	output vgt_pkg::q_status_t q_status
);

	vgt_pkg::q_entry_t             entry_q [vgt_pkg::QUEUE_DEPTH];
	logic [vgt_pkg::QAW-1:0]       wr_ptr_q;
	logic [vgt_pkg::QAW-1:0]       rd_ptr_q;
	logic [vgt_pkg::QCW-1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head           = entry_q[rd_ptr_q];
	assign q_status.count = count_q;
	assign q_status.empty = (count_q == '0);

endmodule

// File: design/vgt_back.sv
// ----------------------------------------------------------------------------
// Vertex gradient tint back end
// Blends base color with the gradient and holds the result for the output.
// ----------------------------------------------------------------------------
module vgt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               blend_mode,
	input  vgt_pkg::q_status_t q_status,
	input  vgt_pkg::q_entry_t  head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output vgt_pkg::out_item_t out_item
);

	logic               out_valid_q;
	vgt_pkg::out_item_t out_item_q;
	vgt_pkg::out_item_t result;
	logic [15:0]        prod_r;
	logic [15:0]        prod_g;
	logic [15:0]        prod_b;
	logic [7:0]         grad_r;
	logic [7:0]         grad_g;
	logic [7:0]         grad_b;

	assign grad_r = head.grad[23:16];
	assign grad_g = head.grad[15:8];
	assign grad_b = head.grad[7:0];

	assign prod_r = {8'd0, head.base_r} * {8'd0, grad_r};
	assign prod_g = {8'd0, head.base_g} * {8'd0, grad_g};
	assign prod_b = {8'd0, head.base_b} * {8'd0, grad_b};

	always_comb begin
		if (blend_mode) begin
			result.shaded_r = prod_r[15:8];
			result.shaded_g = prod_g[15:8];
			result.shaded_b = prod_b[15:8];
		end else begin
			result.shaded_r = (grad_r < head.base_r) ? head.base_r : grad_r;
			result.shaded_g = (grad_g < head.base_g) ? head.base_g : grad_g;
			result.shaded_b = (grad_b < head.base_b) ? head.base_b : grad_b;
		end
		result.last_of_batch = head.batch_end;
	end

	assign pop = !q_status.empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// File: design/vertex_gradient_tint.sv
// ----------------------------------------------------------------------------
// Vertex gradient tint
// Looks up a phase-shifted gradient per vertex and tints the base color.
// ----------------------------------------------------------------------------
// A shaded vertex's result passes the table read register, queue and output
// register before it is offered. One item is accepted per cycle while the queue
// has room; the four-entry queue between lookup and blend stage absorbs output
// stalls before input is held off. Reset clears the phase, the control registers
// and all valid state; the gradient table is not cleared and needs no clearing pass.
module vertex_gradient_tint #(
	parameter int TABLE_ENTRIES = vgt_pkg::TABLE_ENTRIES_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  vgt_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output vgt_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vgt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                            cfg_data
);

	`include "vertex_gradient_tint_defines.svh"

	logic               blend_mode_q;
	logic               gradient_enable_q;
	logic               push_valid;
	vgt_pkg::q_entry_t  push_entry;
	vgt_pkg::q_entry_t  head;
	vgt_pkg::q_status_t q_status;
	logic               pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q      <= 1'b0;
			gradient_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vgt_pkg::CFG_BLEND_MODE:      blend_mode_q      <= cfg_data;
				vgt_pkg::CFG_GRADIENT_ENABLE: gradient_enable_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	vgt_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_item        (in_item),
		.gradient_enable(gradient_enable_q),
		.q_status       (q_status),
		.push_valid     (push_valid),
		.push_entry     (push_entry)
	);

	vgt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.q_status  (q_status)
	);

	vgt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.blend_mode(blend_mode_q),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	`VGT_ASSERT_SAME(a_no_overflow, clk, arst_n, push_valid && !pop, q_status.count < vgt_pkg::QCW'(vgt_pkg::QUEUE_DEPTH), "Queue push while full.")
	`VGT_ASSERT_NEXT(a_shade_reaches_queue, clk, arst_n, in_valid && in_ready && in_item.cmd == vgt_pkg::CMD_SHADE && gradient_enable_q, push_valid, "Enabled vertex item lost before the queue.")
	`VGT_ASSERT_NEXT(a_queue_drains, clk, arst_n, !q_status.empty && (!out_valid || out_ready), out_valid, "Queued vertex not moved to the output.")

endmodule
